/* rtl/holonomic_to_diff_drive_command_unit_defines.svh */
// ============================================================================
// Assertion macros for the holonomic to differential drive command unit
// Concurrent checks, compiled out when SYNTH is defined.
// ============================================================================
`ifndef HOLONOMIC_TO_DIFF_DRIVE_COMMAND_UNIT_DEFINES_SVH
`define HOLONOMIC_TO_DIFF_DRIVE_COMMAND_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define HDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdc check failed");
// next-cycle implication, sampled on clk, off during reset
`define HDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdc check failed");
`else
`define HDC_ASSERT_NOW(label, ante, cons)
`define HDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/hdc_pkg.sv */
// ============================================================================
// hdc_pkg
// Shared widths, constants, arctangent table and pipeline item types.
// ============================================================================
package hdc_pkg;

    localparam int DATA_W      = 16;  // velocity and command fields
    localparam int NUM_CELLS   = 16;  // one square-root digit per cell
    localparam int CELL_IDX_W  = 4;
    localparam int CORDIC_STEPS = 14;
    localparam int HX_W        = 20;  // heading CORDIC x/y
    localparam int YX_W        = 36;  // yaw CORDIC x/y
    localparam int Z_W         = 21;  // angle accumulators, Q3.16
    localparam int SQ_W        = 33;  // square-root remainder and root
    localparam int ANG_W       = 17;  // Q3.12 angle after rounding
    localparam int DIFF_W      = 18;

    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd2;

    localparam logic [14:0] TURN_RATE_RST = 15'd4915;
    localparam logic [14:0] MIN_SPEED_RST = 15'd41;
    localparam logic [13:0] DEADBAND_RST  = 14'd410;

    localparam logic signed [Z_W-1:0]    PI_Q16 = 21'sd205887;
    localparam logic signed [DIFF_W-1:0] PI_Q12 = 18'sd12868;
    localparam logic [SQ_W-1:0]          SPEED_MAX = 33'd32767;

    // arctangent of 2^-i in Q3.16
    localparam logic [Z_W-1:0] ATAN_TAB [0:NUM_CELLS-1] = '{
        21'd51472, 21'd30386, 21'd16055, 21'd8150, 21'd4091, 21'd2047,
        21'd1024, 21'd512, 21'd256, 21'd128, 21'd64, 21'd32,
        21'd16, 21'd8, 21'd4, 21'd2
    };

    // item state carried along the cell chain
    typedef struct packed {
        logic signed [HX_W-1:0]   hx;
        logic signed [HX_W-1:0]   hy;
        logic signed [Z_W-1:0]    hz;
        logic signed [YX_W-1:0]   yx;
        logic signed [YX_W-1:0]   yy;
        logic signed [Z_W-1:0]    yz;
        logic [SQ_W-1:0]          rem;
        logic [SQ_W-1:0]          root;
        logic                     direct;
        logic [DATA_W-1:0]        vx;
        logic [DATA_W-1:0]        dang;
        logic                     req_zero;
        logic                     yaw_zero;
    } cell_data_t;

    // configuration as seen by the output stage
    typedef struct packed {
        logic [14:0] turn_rate;
        logic [14:0] min_speed;
        logic [13:0] deadband;
    } cfg_t;

endpackage

/* rtl/hdc_front.sv */
// ============================================================================
// hdc_front
// Products and sums of squares, then the half-plane turn that seeds the cells.
// ============================================================================
module hdc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [15:0]             vel_x,
    input  logic [15:0]             vel_y,
    input  logic                    direct_mode,
    input  logic [15:0]             direct_angular,
    input  logic [15:0]             quat_x,
    input  logic [15:0]             quat_y,
    input  logic [15:0]             quat_z,
    input  logic [15:0]             quat_w,
    output logic                    out_valid,
    output hdc_pkg::cell_data_t     out_data
);

    localparam int HX_W = hdc_pkg::HX_W;
    localparam int YX_W = hdc_pkg::YX_W;
    localparam int Z_W  = hdc_pkg::Z_W;
    localparam int SQ_W = hdc_pkg::SQ_W;

    logic signed [31:0] vxvx, vyvy, wz, xy, zz, yy2;
    logic [31:0]            sq_next, sq_reg;
    logic signed [YX_W-1:0] yawx_next, yawy_next, yawx_reg, yawy_reg;
    logic [15:0]            vx_reg, vy_reg, dang_reg;
    logic                   direct_reg;
    logic                   a_valid_reg, b_valid_reg;
    hdc_pkg::cell_data_t    b_next, b_reg;

    // multiply the request and quaternion terms
    always_comb
    begin
        vxvx = $signed(vel_x) * $signed(vel_x);
        vyvy = $signed(vel_y) * $signed(vel_y);
        wz   = $signed(quat_w) * $signed(quat_z);
        xy   = $signed(quat_x) * $signed(quat_y);
        zz   = $signed(quat_z) * $signed(quat_z);
        yy2  = $signed(quat_y) * $signed(quat_y);
        sq_next   = $unsigned(vxvx) + $unsigned(vyvy);
        yawy_next = (YX_W'(wz) + YX_W'(xy)) <<< 1;
        yawx_next = (YX_W'(1) <<< 28) - ((YX_W'(zz) + YX_W'(yy2)) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= sq_next;
            yawx_reg   <= yawx_next;
            yawy_reg   <= yawy_next;
            vx_reg     <= vel_x;
            vy_reg     <= vel_y;
            direct_reg <= direct_mode;
            dang_reg   <= direct_angular;
        end
    end

    // turn left half-plane vectors by pi and seed the chain
    always_comb
    begin
        logic signed [HX_W-1:0] hx0, hy0;
        hx0 = HX_W'($signed(vx_reg));
        hy0 = HX_W'($signed(vy_reg));
        b_next          = '0;
        b_next.rem      = SQ_W'(sq_reg);
        b_next.root     = '0;
        b_next.direct   = direct_reg;
        b_next.vx       = vx_reg;
        b_next.dang     = dang_reg;
        b_next.req_zero = (vx_reg == '0) && (vy_reg == '0);
        b_next.yaw_zero = (yawx_reg == '0) && (yawy_reg == '0);
        if (hx0 < 0)
        begin
            b_next.hx = -hx0;
            b_next.hy = -hy0;
            b_next.hz = (hy0 >= 0) ? hdc_pkg::PI_Q16 : -hdc_pkg::PI_Q16;
        end
        else
        begin
            b_next.hx = hx0;
            b_next.hy = hy0;
            b_next.hz = '0;
        end
        if (yawx_reg < 0)
        begin
            b_next.yx = -yawx_reg;
            b_next.yy = -yawy_reg;
            b_next.yz = (yawy_reg >= 0) ? hdc_pkg::PI_Q16 : -hdc_pkg::PI_Q16;
        end
        else
        begin
            b_next.yx = yawx_reg;
            b_next.yy = yawy_reg;
            b_next.yz = Z_W'(0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

/* rtl/hdc_cell.sv */
// ============================================================================
// hdc_cell
// One chain cell: a vectoring CORDIC step for heading and for yaw while CORDIC
// steps remain, and one digit of the integer square root of the speed.
// ============================================================================
module hdc_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic [hdc_pkg::CELL_IDX_W-1:0]        idx,
    input  logic                                  in_valid,
    input  hdc_pkg::cell_data_t                   in_data,
    output logic                                  out_valid,
    output hdc_pkg::cell_data_t                   out_data
);

    localparam int HX_W = hdc_pkg::HX_W;
    localparam int YX_W = hdc_pkg::YX_W;
    localparam int Z_W  = hdc_pkg::Z_W;
    localparam int SQ_W = hdc_pkg::SQ_W;

    logic                data_valid_reg;
    hdc_pkg::cell_data_t data_next, data_reg;

    always_comb
    begin
        logic signed [HX_W-1:0] hxs, hys, hx, hy;
        logic signed [YX_W-1:0] yxs, yys, yx, yy;
        logic signed [Z_W-1:0]  at;
        logic [SQ_W-1:0]        bitv, trial;
        logic [5:0]             bsh;
        hx  = in_data.hx;
        hy  = in_data.hy;
        yx  = in_data.yx;
        yy  = in_data.yy;
        hxs = hx >>> idx;
        hys = hy >>> idx;
        yxs = yx >>> idx;
        yys = yy >>> idx;
        at  = $signed(hdc_pkg::ATAN_TAB[idx]);
        bsh   = 6'd30 - {1'b0, idx, 1'b0};
        bitv  = SQ_W'(1) << bsh;
        trial = in_data.root + bitv;
        data_next = in_data;

        // rotate towards the x axis while steps remain
        if (32'(idx) < hdc_pkg::CORDIC_STEPS)
        begin
            if (hy > 0)
            begin
                data_next.hx = hx + hys;
                data_next.hy = hy - hxs;
                data_next.hz = in_data.hz + at;
            end
            else
            begin
                data_next.hx = hx - hys;
                data_next.hy = hy + hxs;
                data_next.hz = in_data.hz - at;
            end
            if (yy > 0)
            begin
                data_next.yx = yx + yys;
                data_next.yy = yy - yxs;
                data_next.yz = in_data.yz + at;
            end
            else
            begin
                data_next.yx = yx - yys;
                data_next.yy = yy + yxs;
                data_next.yz = in_data.yz - at;
            end
        end

        // settle one root digit
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + bitv;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_valid_reg <= 1'b0;
        else if (adv)
            data_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    assign out_valid = data_valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/hdc_back.sv */
// ============================================================================
// hdc_back
// Rounds both angles, forms the heading error and the bang-bang turn, clamps
// the speed and holds the result item for the output channel.
// ============================================================================
module hdc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  hdc_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  hdc_pkg::cell_data_t  in_data,
    output logic                 out_valid,
    output logic [15:0]          linear_cmd,
    output logic [15:0]          angular_cmd
);

    localparam int Z_W    = hdc_pkg::Z_W;
    localparam int ANG_W  = hdc_pkg::ANG_W;
    localparam int DIFF_W = hdc_pkg::DIFF_W;

    logic        res_valid_reg;
    logic [15:0] lin_next, ang_next, lin_reg, ang_reg;

    always_comb
    begin
        logic signed [Z_W-1:0]    hsum, ysum;
        logic signed [ANG_W-1:0]  heading, yaw;
        logic signed [DIFF_W-1:0] diff, db;
        logic [15:0]              tr, spd;
        hsum    = in_data.hz + Z_W'(8);
        ysum    = in_data.yz + Z_W'(8);
        heading = ANG_W'(hsum >>> 4);
        yaw     = in_data.yaw_zero ? '0 : ANG_W'(ysum >>> 4);
        diff    = DIFF_W'(yaw) - DIFF_W'(heading);
        db      = $signed({4'b0, cfg.deadband});
        tr      = {1'b0, cfg.turn_rate};

        // clamp the speed
        if (in_data.root < hdc_pkg::SQ_W'(cfg.min_speed))
            spd = '0;
        else if (in_data.root > hdc_pkg::SPEED_MAX)
            spd = 16'(hdc_pkg::SPEED_MAX);
        else
            spd = in_data.root[15:0];

        priority if (in_data.direct)
        begin
            lin_next = in_data.vx;
            ang_next = in_data.dang;
        end
        else if (in_data.req_zero)
        begin
            lin_next = '0;
            ang_next = '0;
        end
        else
        begin
            lin_next = spd;
            priority if (diff > db)
                ang_next = (diff < hdc_pkg::PI_Q12) ? -tr : tr;
            else if (diff < -db)
                ang_next = (diff < -hdc_pkg::PI_Q12) ? -tr : tr;
            else
                ang_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign linear_cmd  = lin_reg;
    assign angular_cmd = ang_reg;

endmodule

/* rtl/holonomic_to_diff_drive_command_unit.sv */
// ============================================================================
// holonomic_to_diff_drive_command_unit
// Turns a planar velocity request and an orientation into a forward speed
// and a bang-bang turn command, through a chain of CORDIC/square-root cells.
// ============================================================================
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | vel_x vel_y direct_mode direct_angular quat_*
//  out      | out_valid / out_stall| linear_cmd angular_cmd
//  cfg      | cfg_we               | cfg_index cfg_data
//
//  One item enters per cycle while the output is not stalled; the path is two
//  front stages, sixteen cells (one root digit each, CORDIC steps in the first
//  fourteen) and the output register.
//  Reset clears the valid bits and loads the register defaults; no sweep.
//  A stalled output freezes the whole chain, and in_stall follows it.
`include "holonomic_to_diff_drive_command_unit_defines.svh"

module holonomic_to_diff_drive_command_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [15:0]                vel_x,
    input  logic [15:0]                vel_y,
    input  logic                       direct_mode,
    input  logic [15:0]                direct_angular,
    input  logic [15:0]                quat_x,
    input  logic [15:0]                quat_y,
    input  logic [15:0]                quat_z,
    input  logic [15:0]                quat_w,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                linear_cmd,
    output logic [15:0]                angular_cmd,
    input  logic                       cfg_we,
    input  logic [hdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hdc_pkg::CFG_W-1:0]  cfg_data
);

    localparam int NUM_CELLS = hdc_pkg::NUM_CELLS;

    logic                adv;
    logic [14:0]         turn_rate_reg, min_speed_reg;
    logic [13:0]         deadband_reg;
    hdc_pkg::cfg_t       cfg;
    logic                chain_valid [0:NUM_CELLS];
    hdc_pkg::cell_data_t chain_data  [0:NUM_CELLS];

    // advance whenever the output item is gone or being taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg <= hdc_pkg::TURN_RATE_RST;
            min_speed_reg <= hdc_pkg::MIN_SPEED_RST;
            deadband_reg  <= hdc_pkg::DEADBAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hdc_pkg::REG_TURN_RATE: turn_rate_reg <= cfg_data;
                hdc_pkg::REG_MIN_SPEED: min_speed_reg <= cfg_data;
                hdc_pkg::REG_DEADBAND:  deadband_reg  <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign cfg.turn_rate = turn_rate_reg;
    assign cfg.min_speed = min_speed_reg;
    assign cfg.deadband  = deadband_reg;

    hdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .in_valid       (in_valid),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .direct_mode    (direct_mode),
        .direct_angular (direct_angular),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z),
        .quat_w         (quat_w),
        .out_valid      (chain_valid[0]),
        .out_data       (chain_data[0])
    );

    // row of cells
    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        hdc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .idx       (hdc_pkg::CELL_IDX_W'(g)),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    hdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .cfg         (cfg),
        .in_valid    (chain_valid[NUM_CELLS]),
        .in_data     (chain_data[NUM_CELLS]),
        .out_valid   (out_valid),
        .linear_cmd  (linear_cmd),
        .angular_cmd (angular_cmd)
    );

    // checks
    `HDC_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall)
    `HDC_ASSERT_NOW(a_free_flow, !out_stall, !in_stall)
    `HDC_ASSERT_NEXT(a_cfg_turn, cfg_we && cfg_index == hdc_pkg::REG_TURN_RATE,
                     turn_rate_reg == $past(cfg_data))

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Command converter bench
// Drives planar velocity requests with orientations into the command unit,
// predicts linear speed and bang-bang turn per item and checks every result
// in order, across several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] vx, vy, dang, qx, qy, qz, qw;
        logic        direct;
    } request_t;

    typedef struct {
        logic [15:0] lin, ang;
    } command_t;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [15:0] vel_x, vel_y, direct_angular, quat_x, quat_y, quat_z, quat_w;
    logic        direct_mode;
    logic [15:0] linear_cmd, angular_cmd;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    request_t pending_requests[$];
    command_t expected_commands[$];
    int  sender_idle_pct, receiver_stall_pct;
    int  hold_request_seq, hold_seen_seq, hold_left;
    int  mismatches, results_seen, items_sent, quiet_cycles;
    int  turn_rate_q, min_speed_q, deadband_q;

    holonomic_to_diff_drive_command_unit u_dut (.*);

    always #6 clk = ~clk;

    // atan2 in Q3.12 via vectoring CORDIC, Q3.16 internally
    function automatic longint heading_of(longint y, longint x);
        longint z, base, xs, ys;
        longint tab[14] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8};
        z = 0;
        base = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 14; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += tab[i];
            end
            else
            begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        return (z + base + 8) >>> 4;
    endfunction

    function automatic longint speed_of(longint sq);
        longint rem, root, b;
        rem = sq;
        root = 0;
        b = 64'sd1 << 62;
        while (b > sq)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic command_t drive_command(request_t r);
        command_t c;
        longint vx, vy, qx, qy, qz, qw, spd, hdg, yaw, diff, lin, ang;
        vx = longint'(signed'(r.vx));
        vy = longint'(signed'(r.vy));
        lin = 0;
        ang = 0;
        if (r.direct)
        begin
            lin = vx;
            ang = longint'(signed'(r.dang));
        end
        else if (vx != 0 || vy != 0)
        begin
            qx = longint'(signed'(r.qx));
            qy = longint'(signed'(r.qy));
            qz = longint'(signed'(r.qz));
            qw = longint'(signed'(r.qw));
            spd = speed_of(vx * vx + vy * vy);
            if (spd < min_speed_q)
                spd = 0;
            if (spd > 32767)
                spd = 32767;
            lin = spd;
            hdg = heading_of(vy, vx);
            yaw = heading_of(2 * (qw * qz + qx * qy),
                             (64'sd1 << 28) - 2 * (qz * qz + qy * qy));
            diff = yaw - hdg;
            if (diff > deadband_q)
                ang = (diff < 12868) ? -turn_rate_q : turn_rate_q;
            else if (diff < -deadband_q)
                ang = (diff < -12868) ? -turn_rate_q : turn_rate_q;
        end
        c.lin = lin[15:0];
        c.ang = ang[15:0];
        return c;
    endfunction

    // feed the next item once the current one has gone in
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                request_t r;
                r = pending_requests.pop_front();
                in_valid       <= 1'b1;
                vel_x          <= r.vx;
                vel_y          <= r.vy;
                direct_mode    <= r.direct;
                direct_angular <= r.dang;
                quat_x         <= r.qx;
                quat_y         <= r.qy;
                quat_z         <= r.qz;
                quat_w         <= r.qw;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // stall the output at random, or hold off for a long stretch on request
    always @(posedge clk)
    begin
        if (hold_request_seq != hold_seen_seq)
        begin
            hold_seen_seq <= hold_request_seq;
            hold_left <= 80;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // predict on input acceptance, check on output acceptance, watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            automatic bit moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                request_t r;
                r.vx = vel_x; r.vy = vel_y; r.direct = direct_mode;
                r.dang = direct_angular;
                r.qx = quat_x; r.qy = quat_y; r.qz = quat_z; r.qw = quat_w;
                expected_commands.push_back(drive_command(r));
                items_sent++;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                results_seen++;
                if (expected_commands.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result lin=%0d ang=%0d",
                                 signed'(linear_cmd), signed'(angular_cmd));
                end
                else
                begin
                    command_t e;
                    e = expected_commands.pop_front();
                    if (e.lin !== linear_cmd || e.ang !== angular_cmd)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: lin exp %0d got %0d, ang exp %0d got %0d",
                                     signed'(e.lin), signed'(linear_cmd),
                                     signed'(e.ang), signed'(angular_cmd));
                    end
                end
            end
            if (moved || (pending_requests.size() == 0 && expected_commands.size() == 0))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_commands.size());
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic request_t make_request(int vx, int vy, bit direct, int dang,
                                              int qx, int qy, int qz, int qw);
        request_t r;
        r.vx = vx[15:0]; r.vy = vy[15:0]; r.direct = direct; r.dang = dang[15:0];
        r.qx = qx[15:0]; r.qy = qy[15:0]; r.qz = qz[15:0]; r.qw = qw[15:0];
        return r;
    endfunction

    function automatic int random_velocity();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 400) - 200;
            2: return 0;
            default: return $urandom_range(0, 8000) - 4000;
        endcase
    endfunction

    function automatic int random_quat();
        return $urandom_range(0, 32768) - 16384;
    endfunction

    task automatic queue_random(int count);
        request_t r;
        repeat (count)
        begin
            r = make_request(random_velocity(), random_velocity(),
                             $urandom_range(0, 99) < 20,
                             $urandom_range(0, 65535) - 32768,
                             random_quat(), random_quat(), random_quat(), random_quat());
            pending_requests.push_back(r);
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || expected_commands.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[14:0];
        if (idx == hdc_pkg::REG_TURN_RATE)
            turn_rate_q = value & 32'h7fff;
        else if (idx == hdc_pkg::REG_MIN_SPEED)
            min_speed_q = value & 32'h7fff;
        else if (idx == hdc_pkg::REG_DEADBAND)
            deadband_q = value & 32'h3fff;
        @(posedge clk);
    endtask

    task automatic set_registers(int tr, int ms, int db);
        write_reg(hdc_pkg::REG_TURN_RATE, tr);
        write_reg(hdc_pkg::REG_MIN_SPEED, ms);
        write_reg(hdc_pkg::REG_DEADBAND, db);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0; out_stall <= 1'b0; cfg_we <= 1'b0;
        cfg_index <= '0; cfg_data <= '0;
        vel_x <= '0; vel_y <= '0; direct_mode <= 1'b0; direct_angular <= '0;
        quat_x <= '0; quat_y <= '0; quat_z <= '0; quat_w <= '0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        hold_request_seq = 0; hold_seen_seq = 0; hold_left = 0;
        mismatches = 0; results_seen = 0; items_sent = 0; quiet_cycles = 0;
        turn_rate_q = 4915; min_speed_q = 41; deadband_q = 410;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset settings
        pending_requests.push_back(make_request(0, 0, 0, 1234, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(0, 0, 1, -32768, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(32767, -5, 1, 32767, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(-32768, -32768, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(32767, 32767, 0, 0, 0, 0, 16384, 0));
        pending_requests.push_back(make_request(-4096, 0, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(-4096, 0, 0, 0, 0, 0, 16384, 0));
        pending_requests.push_back(make_request(0, -4096, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(0, 4096, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(40, 0, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(41, 0, 0, 0, 0, 0, 0, 16384));
        pending_requests.push_back(make_request(4096, 0, 0, 0, 0, 0, 1640, 16302));
        pending_requests.push_back(make_request(4096, 0, 0, 0, 0, 0, -1640, 16302));
        pending_requests.push_back(make_request(4096, 0, 0, 0, 0, 0, 1580, 16308));
        pending_requests.push_back(make_request(-4096, 1, 0, 0, 0, 0, -16384, 100));
        pending_requests.push_back(make_request(-4096, -1, 0, 0, 0, 0, 16384, 100));
        pending_requests.push_back(make_request(100, 100, 0, 0, -16384, 16384, -16384, -16384));
        pending_requests.push_back(make_request(-100, 50, 0, 0, 16384, -16384, 16384, 16384));
        pending_requests.push_back(make_request(3, -7, 0, 0, 0, 0, 0, 0));
        queue_random(130);
        wait_idle();

        // wide turn, no speed floor, no deadband; sender idles
        set_registers(32767, 0, 0);
        sender_idle_pct = 66;
        queue_random(160);
        wait_idle();

        // zero turn, highest floor, deadband of pi; receiver stalls and holds off
        set_registers(0, 32767, 12868);
        sender_idle_pct = 0;
        receiver_stall_pct = 66;
        hold_request_seq = hold_request_seq + 1;
        queue_random(160);
        wait_idle();

        // smallest nonzero settings; both sides idle
        set_registers(1, 1, 1);
        write_reg(2'd3, 15'h7fff);
        cfg_we <= 1'b0;
        sender_idle_pct = 27;
        receiver_stall_pct = 27;
        queue_random(160);
        wait_idle();

        // random settings, full rate
        set_registers($urandom_range(0, 32767), $urandom_range(0, 2000),
                      $urandom_range(0, 16383));
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_random(170);
        wait_idle();

        $display("covered %0d items, %0d results over five register settings", items_sent,
                 results_seen);
        $display("idling: none, sender, receiver with long hold-off, both; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_commands.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* holonomic_to_diff_drive_command_unit.f */
+incdir+rtl
rtl/hdc_pkg.sv
rtl/hdc_front.sv
rtl/hdc_cell.sv
rtl/hdc_back.sv
rtl/holonomic_to_diff_drive_command_unit.sv
bench/testbench.sv
